// ===== hdl/utt_pkg.sv =====
// utt_pkg: shared types, constants and utf-8 byte encoder for the utf-16 to utf-8 transcoder
// no dependencies
package utt_pkg;

  // default number of jobs queued between front and back
  localparam int unsigned UttQueueDepth = 2;

  // code point width (up to U+10FFFF)
  localparam int unsigned CpW = 21;

  typedef logic [CpW-1:0] cp_t;
  typedef logic [2:0]     blen_t;  // utf-8 byte count of a code point, 0 = none
  typedef logic [1:0]     bidx_t;  // byte position inside a code point

  // one job for the back end: up to two code points, a before b
  typedef struct packed {
    cp_t   cp_a;
    blen_t len_a;
    cp_t   cp_b;
    blen_t len_b;
    logic  last;
  } job_t;

  localparam cp_t   ReplacementChar = 21'h00fffd;
  localparam cp_t   SuppBase        = 21'h010000;
  localparam logic [15:0] HighFirst = 16'hd800;
  localparam logic [15:0] HighLast  = 16'hdbff;
  localparam logic [15:0] LowFirst  = 16'hdc00;
  localparam logic [15:0] LowLast   = 16'hdfff;
  localparam logic [15:0] OneByteMax = 16'h007f;
  localparam logic [15:0] TwoByteMax = 16'h07ff;

  localparam blen_t LenNone = 3'd0;
  localparam blen_t LenOne  = 3'd1;
  localparam blen_t LenTwo  = 3'd2;
  localparam blen_t LenRepl = 3'd3;
  localparam blen_t LenSupp = 3'd4;

  // utf-8 length of a basic-plane code point
  function automatic blen_t bmp_len(logic [15:0] unit);
    blen_t len;
    if (unit <= OneByteMax) begin
      len = LenOne;
    end else if (unit <= TwoByteMax) begin
      len = LenTwo;
    end else begin
      len = LenRepl;
    end
    return len;
  endfunction

  // byte idx of the utf-8 form of cp, given its length
  function automatic logic [7:0] enc_byte(cp_t cp, blen_t len, bidx_t idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      LenOne: b = {1'b0, cp[6:0]};
      LenTwo: begin
        if (idx == 2'd0) b = {3'b110, cp[10:6]};
        else             b = {2'b10, cp[5:0]};
      end
      LenRepl: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LenSupp: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/utt_front.sv =====
// utt_front: accepts code units, tracks surrogate and termination state, builds jobs
// depends on utt_pkg
module utt_front import utt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        push_o,
  output job_t        job_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       term_q, term_d;

  logic  is_high, is_low, is_zero;
  cp_t   pre_cp, alone_cp;
  blen_t pre_len, alone_len;
  logic  handle_alone;

  assign is_high = (code_unit_i >= HighFirst) && (code_unit_i <= HighLast);
  assign is_low  = (code_unit_i >= LowFirst) && (code_unit_i <= LowLast);
  assign is_zero = (code_unit_i == 16'h0000);

  always_comb begin
    pre_cp       = ReplacementChar;
    pre_len      = LenNone;
    alone_cp     = CpW'(code_unit_i);
    alone_len    = LenNone;
    handle_alone = !term_q;
    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    term_d       = term_q;

    if (!term_q) begin
      if (held_valid_q) begin
        if (is_low) begin
          // surrogate pair
          pre_cp       = SuppBase + CpW'({held_bits_q, code_unit_i[9:0]});
          pre_len      = LenSupp;
          handle_alone = 1'b0;
        end else begin
          pre_len = LenRepl;
        end
        held_valid_d = 1'b0;
      end
      if (handle_alone) begin
        if (is_zero) begin
          term_d = 1'b1;
        end else if (is_high) begin
          if (last_unit_i) begin
            alone_cp  = ReplacementChar;
            alone_len = LenRepl;
          end else begin
            held_valid_d = 1'b1;
            held_bits_d  = code_unit_i[9:0];
          end
        end else if (is_low) begin
          alone_cp  = ReplacementChar;
          alone_len = LenRepl;
        end else begin
          alone_len = bmp_len(code_unit_i);
        end
      end
    end

    if (last_unit_i) begin
      held_valid_d = 1'b0;
      term_d       = 1'b0;
    end

    // pack so that a single code point always sits in slot a
    if (pre_len != LenNone) begin
      job_o.cp_a  = pre_cp;
      job_o.len_a = pre_len;
      job_o.cp_b  = alone_cp;
      job_o.len_b = alone_len;
    end else begin
      job_o.cp_a  = alone_cp;
      job_o.len_a = alone_len;
      job_o.cp_b  = alone_cp;
      job_o.len_b = LenNone;
    end
    job_o.last = last_unit_i;
  end

  assign push_o = accept_i && ((job_o.len_a != LenNone) || last_unit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      term_q       <= 1'b0;
    end else if (accept_i) begin
      held_valid_q <= held_valid_d;
      term_q       <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_bits_q <= held_bits_d;
    end
  end

endmodule

// ===== hdl/utt_fifo.sv =====
// utt_fifo: small job queue between front and back, register based
// depends on utt_pkg
module utt_fifo import utt_pkg::*; #(
  parameter int unsigned Depth = UttQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/utt_back.sv =====
// utt_back: walks a queued job byte by byte into the output register
// depends on utt_pkg
module utt_back import utt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o
);

  logic       phase_q, phase_d;
  bidx_t      idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       bvalid_q, rlast_q, sdone_q;

  logic       load, empty_job, last_of_point, last_of_job;
  cp_t        cur_cp;
  blen_t      cur_len;
  logic [7:0] cur_byte;

  assign load      = !out_valid_q || out_ready_i;
  assign empty_job = (job_i.len_a == LenNone);
  assign cur_cp    = phase_q ? job_i.cp_b : job_i.cp_a;
  assign cur_len   = phase_q ? job_i.len_b : job_i.len_a;
  assign cur_byte  = enc_byte(cur_cp, cur_len, idx_q);

  assign last_of_point = ({1'b0, idx_q} + 3'd1) == cur_len;
  assign last_of_job   = empty_job ||
                         (last_of_point && (phase_q || (job_i.len_b == LenNone)));

  assign pop_o = load && job_valid_i && last_of_job;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        if (last_of_job) begin
          phase_d = 1'b0;
          idx_d   = '0;
        end else if (last_of_point) begin
          phase_d = 1'b1;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && job_valid_i) begin
      byte_q   <= empty_job ? 8'h00 : cur_byte;
      bvalid_q <= !empty_job;
      rlast_q  <= last_of_job;
      sdone_q  <= last_of_job && job_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign run_last_o    = rlast_q;
  assign string_done_o = sdone_q;

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// utf16_to_utf8_transcoder: one utf-16 code unit in per transfer, one utf-8 byte out per transfer
// throughput: one output byte per cycle unless out_ready_i is low; a unit gives 0 to 6 bytes;
//   units that give no byte are queued only when they end a string; the output register sets the pace
// reset: rst_ni async active low clears surrogate/termination state, queue and output valid
// depends on utt_pkg, utt_front, utt_fifo, utt_back
module utf16_to_utf8_transcoder import utt_pkg::*; #(
  parameter int unsigned QueueDepth = UttQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output logic        string_done_o
);

  // front end to queue
  logic in_accept;
  logic push;
  job_t push_job;

  // queue to back end
  logic q_full;
  logic q_valid;
  logic pop;
  job_t head_job;

  // input transfer whenever the queue has room; independent of the output side
  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && in_ready_o;

  // classify the unit, pair surrogates, decide which code points to emit
  utt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .push_o      (push),
    .job_o       (push_job)
  );

  // decoupling queue, only units with something to emit are queued
  utt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_job)
  );

  // serialize each job into bytes, one per output transfer
  utt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

`ifndef ASSERT_OFF
  // an empty end marker only closes a string
  a_marker_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (run_last_o && string_done_o && out_byte_o == 8'h00))
    else $error("empty marker without end flags");

  // end of string is always end of the unit's run
  a_done_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_done_o) |-> run_last_o)
    else $error("string_done without run_last");

  // a queued job leaves the queue only on an output load
  a_pop_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && run_last_o)
    else $error("job retired without its final byte");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for utf16_to_utf8_transcoder, random idling on both channels
// depends on utt_pkg and the transcoder rtl; predicts utf-8 bytes per accepted code unit

module tb_top import utt_pkg::*; ();

  localparam int unsigned ClkHalf     = 4;       // 8 ns period
  localparam int unsigned ResetCycles = 4;
  localparam int unsigned CycleLimit  = 200000;  // far above the slowest legal run
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned RandomUnits = 105;

  // utf-8 lead and continuation markers
  localparam logic [7:0] Lead2    = 8'hc0;
  localparam logic [7:0] Lead3    = 8'he0;
  localparam logic [7:0] Lead4    = 8'hf0;
  localparam logic [7:0] ContMark = 8'h80;

  // one code unit waiting to be driven; drain holds it back until all bytes are out
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        drain;
  } unit_item_t;

  // one expected output transfer
  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       run_last;
    logic       done;
  } utf8_byte_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_unit_i  = '0;
  logic        last_unit_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        run_last_o;
  logic        string_done_o;

  unit_item_t  unit_queue[$];      // units not yet presented
  utf8_byte_t  expected_bytes[$];  // bytes predicted but not yet seen
  int unsigned total_units    = 0;
  int unsigned units_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // predictor state: held high surrogate and termination flag
  logic [9:0] held_bits   = '0;
  logic       held_v      = 1'b0;
  logic       halted      = 1'b0;

  utf16_to_utf8_transcoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .last_unit_i  (last_unit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_done_o(string_done_o)
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void put_byte(logic [7:0] b);
    utf8_byte_t r;
    r.data     = b;
    r.bvalid   = 1'b1;
    r.run_last = 1'b0;
    r.done     = 1'b0;
    expected_bytes.insert(expected_bytes.size(), r);
  endfunction

  // utf-8 form of one code point, one to four bytes
  function automatic void put_point(logic [20:0] cp);
    if (cp <= OneByteMax) begin
      put_byte(cp[7:0]);
    end else if (cp <= TwoByteMax) begin
      put_byte(Lead2 | cp[10:6]);
      put_byte(ContMark | cp[5:0]);
    end else if (cp < SuppBase) begin
      put_byte(Lead3 | cp[15:12]);
      put_byte(ContMark | cp[11:6]);
      put_byte(ContMark | cp[5:0]);
    end else begin
      put_byte(Lead4 | cp[20:18]);
      put_byte(ContMark | cp[17:12]);
      put_byte(ContMark | cp[11:6]);
      put_byte(ContMark | cp[5:0]);
    end
  endfunction

  // all bytes that one accepted code unit releases, with run and string flags
  function automatic void encode_unit(logic [15:0] unit, logic last);
    int unsigned n0;
    logic        alone;
    logic        is_hi;
    logic        is_lo;
    utf8_byte_t  marker;
    n0    = expected_bytes.size();
    is_hi = (unit >= HighFirst) && (unit <= HighLast);
    is_lo = (unit >= LowFirst) && (unit <= LowLast);
    if (!halted) begin
      alone = 1'b1;
      if (held_v) begin
        if (is_lo) begin
          // low ten bits of both halves line up with the surrogate bases
          put_point(SuppBase + {1'b0, held_bits, unit[9:0]});
          alone = 1'b0;
        end else begin
          put_point(ReplacementChar);
        end
        held_v    = 1'b0;
        held_bits = '0;
      end
      if (alone) begin
        if (unit == 16'h0000) begin
          halted = 1'b1;
        end else if (is_hi) begin
          if (last) begin
            put_point(ReplacementChar);
          end else begin
            held_v    = 1'b1;
            held_bits = unit[9:0];
          end
        end else if (is_lo) begin
          put_point(ReplacementChar);
        end else begin
          put_point({5'd0, unit});
        end
      end
    end
    if (last) begin
      if (expected_bytes.size() == n0) begin
        // empty end marker
        marker.data     = 8'h00;
        marker.bvalid   = 1'b0;
        marker.run_last = 1'b0;
        marker.done     = 1'b0;
        expected_bytes.insert(expected_bytes.size(), marker);
      end
      expected_bytes[expected_bytes.size()-1].done = 1'b1;
      held_v    = 1'b0;
      held_bits = '0;
      halted    = 1'b0;
    end
    if (expected_bytes.size() > n0) begin
      expected_bytes[expected_bytes.size()-1].run_last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // idling: thirds of the run by accepted units
  //   first  sender 6 %, receiver 72 %
  //   second sender 72 %, receiver 6 %
  //   last   no idling at all
  // ---------------------------------------------------------------------------

  function automatic int unsigned idle_pct(logic rx_side);
    if (units_accepted < total_units / 3) begin
      return rx_side ? 72 : 6;
    end else if (units_accepted < (2 * total_units) / 3) begin
      return rx_side ? 6 : 72;
    end
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued units, holds valid and payload until the transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    logic       take;
    unit_item_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        encode_unit(code_unit_i, last_unit_i);
        units_accepted++;
      end
      // payload may change only when nothing is pending or it just went through
      if (!in_valid_i || in_ready_o) begin
        take = 1'b0;
        if (unit_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          // a drain item waits until every predicted byte has been seen
          if (!unit_queue[0].drain || expected_bytes.size() == 0) begin
            take = 1'b1;
          end
        end
        if (take) begin
          nxt = unit_queue.pop_front();
          in_valid_i  <= 1'b1;
          code_unit_i <= nxt.unit;
          last_unit_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, in-order check of every output transfer
  // ---------------------------------------------------------------------------

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    utf8_byte_t want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1));
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: output transfer with nothing expected, actual byte %h valid %b %b %b",
                   $time, out_byte_o, byte_valid_o, run_last_o, string_done_o);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.data, out_byte_o);
          check_field("byte_valid", want.bvalid, byte_valid_o);
          check_field("run_last", want.run_last, run_last_o);
          check_field("string_done", want.done, string_done_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_unit(logic [15:0] unit, logic last, logic drain);
    unit_item_t it;
    it.unit  = unit;
    it.last  = last;
    it.drain = drain;
    unit_queue.insert(unit_queue.size(), it);
  endfunction

  // basic-plane unit of three utf-8 bytes, never a surrogate
  function automatic logic [15:0] rand_wide_unit();
    logic [15:0] u;
    u = 16'($urandom_range(16'hf7ff, 16'h0800));
    if (u >= HighFirst) u = u + 16'h0800;
    return u;
  endfunction

  function automatic logic [15:0] rand_high();
    return HighFirst | 16'($urandom_range(1023));
  endfunction

  function automatic logic [15:0] rand_low();
    return LowFirst | 16'($urandom_range(1023));
  endfunction

  initial begin
    logic [15:0] str[$];
    int unsigned n_len;
    int unsigned pick;
    logic        noisy;
    logic        first_random;

    // length boundaries of the encoding, then smallest and largest pair
    add_unit(16'h007f, 1'b0, 1'b0);
    add_unit(16'h0080, 1'b0, 1'b0);
    add_unit(16'h07ff, 1'b0, 1'b0);
    add_unit(16'h0800, 1'b0, 1'b0);
    add_unit(16'hffff, 1'b0, 1'b0);
    add_unit(HighFirst, 1'b0, 1'b0);
    add_unit(LowFirst, 1'b0, 1'b0);
    add_unit(HighLast, 1'b0, 1'b0);
    add_unit(LowLast, 1'b1, 1'b0);
    // held high surrogate broken by a plain unit, then by another high one
    add_unit(16'hd800, 1'b0, 1'b0);
    add_unit(16'h0041, 1'b0, 1'b0);
    add_unit(16'hdabc, 1'b0, 1'b0);
    add_unit(16'hdbff, 1'b0, 1'b0);
    add_unit(16'hdc01, 1'b0, 1'b0);
    // lone low surrogate
    add_unit(16'hdfff, 1'b0, 1'b0);
    // held surrogate then zero: replacement, then units ignored up to the end
    add_unit(16'hd801, 1'b0, 1'b0);
    add_unit(16'h0000, 1'b0, 1'b0);
    add_unit(16'h1234, 1'b0, 1'b0);
    add_unit(16'h0041, 1'b1, 1'b0);
    // high surrogate as the final unit
    add_unit(16'hdbff, 1'b1, 1'b0);
    // string of only a zero unit: empty end marker
    add_unit(16'h0000, 1'b1, 1'b0);
    // held surrogate broken by a final two-byte unit, then by a final high one
    add_unit(16'hd800, 1'b0, 1'b0);
    add_unit(16'h00e9, 1'b1, 1'b0);
    add_unit(16'hd800, 1'b0, 1'b0);
    add_unit(16'hdbff, 1'b1, 1'b0);

    // random strings, mostly well formed, some with broken pairs and zeros
    first_random = 1'b1;
    while (unit_queue.size() < 25 + RandomUnits) begin
      str.delete();
      n_len = $urandom_range(8, 1);
      noisy = ($urandom_range(99) < 20);
      for (int unsigned k = 0; k < n_len; k++) begin
        pick = $urandom_range(99);
        if (noisy && pick < 40) begin
          case ($urandom_range(3))
            0:       str.insert(str.size(), rand_high());
            1:       str.insert(str.size(), rand_low());
            2:       str.insert(str.size(), 16'h0000);
            default: str.insert(str.size(), 16'($urandom_range(16'hffff)));
          endcase
        end else if (pick < 30) begin
          str.insert(str.size(), 16'($urandom_range(16'h007f, 1)));
        end else if (pick < 50) begin
          str.insert(str.size(), 16'($urandom_range(16'h07ff, 16'h0080)));
        end else if (pick < 75) begin
          str.insert(str.size(), rand_wide_unit());
        end else begin
          str.insert(str.size(), rand_high());
          str.insert(str.size(), rand_low());
        end
      end
      foreach (str[k]) begin
        // the first random unit waits until the directed part has fully drained
        add_unit(str[k], k == str.size() - 1, first_random);
        first_random = 1'b0;
      end
    end
    total_units = unit_queue.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (units_accepted < total_units) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    // any late extra transfer shows up in the monitor during this tail
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
